[rtl/sdf_pkg.sv]
// Package for the signed decimal formatter.
// Holds widths, ASCII codes and the result bundle passed from converter to emitter.
// No dependencies.
`timescale 1ns / 1ps

package sdf_pkg;

	// Width of the signed input value
	localparam int VALUE_W = 32;
	// Decimal digits needed for the largest magnitude (2147483648)
	localparam int NUM_DIGITS = 10;
	// Bits of one BCD digit
	localparam int BCD_W = 4;
	// Width of a digit index
	localparam int IDX_W = $clog2(NUM_DIGITS);
	// Width of the shift counter
	localparam int CNT_W = $clog2(VALUE_W);
	// Width of one ASCII code
	localparam int CHAR_W = 7;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

	// Finished conversion handed from the converter to the emitter
	typedef struct packed {
		logic                                valid;
		logic                                space;
		logic                                neg;
		logic [NUM_DIGITS-1:0][BCD_W-1:0]    digits;
	} conv_result_t;

endpackage

[rtl/sdf_bcd_cell.sv]
// One BCD digit cell of the double-dabble chain.
// Adds three when the digit is five or more, then shifts in the bit from the lower cell.
// Depends on sdf_pkg.
`timescale 1ns / 1ps

module sdf_bcd_cell (
	input  logic                        clk,
	input  logic                        clr,
	input  logic                        shift,
	input  logic                        din,
	output logic                        dout,
	output logic [sdf_pkg::BCD_W-1:0]   digit
);

	logic [sdf_pkg::BCD_W-1:0] digit_q;
	logic [sdf_pkg::BCD_W-1:0] adj;

	// Correct the digit before it doubles
	always_comb begin
		adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	end

	assign dout  = adj[sdf_pkg::BCD_W-1];
	assign digit = digit_q;

	// Clear on a new item, shift one bit per cycle while running
	always_ff @(posedge clk) begin
		if (clr) begin
			digit_q <= '0;
		end else if (shift) begin
			digit_q <= {adj[sdf_pkg::BCD_W-2:0], din};
		end
	end

endmodule

[rtl/sdf_convert.sv]
// Binary to BCD converter: a magnitude shift register feeding a chain of BCD cells.
// Takes one value, shifts its 32-bit magnitude in MSB first, then holds the result.
// Depends on sdf_pkg and sdf_bcd_cell.
`timescale 1ns / 1ps

module sdf_convert (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  logic [sdf_pkg::VALUE_W-1:0]      value,
	input  logic                             space,
	input  logic                             take,
	output logic                             idle,
	output sdf_pkg::conv_result_t            res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [sdf_pkg::CNT_W-1:0] CNT_LAST = sdf_pkg::CNT_W'(sdf_pkg::VALUE_W - 1);

	logic [1:0]                          state_q;
	logic [sdf_pkg::CNT_W-1:0]           cnt_q;
	logic [sdf_pkg::VALUE_W-1:0]         mag_q;
	logic                                space_q;
	logic                                neg_q;
	logic                                running;
	logic [sdf_pkg::NUM_DIGITS-1:0]      carry;
	logic [sdf_pkg::NUM_DIGITS-1:0][sdf_pkg::BCD_W-1:0] digits;

	assign running = (state_q == ST_RUN);
	assign idle    = (state_q == ST_IDLE);

	// Sequence: load, shift every magnitude bit in, wait for the emitter to take the digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (load) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the magnitude in unsigned arithmetic and advance it one bit per cycle
	always_ff @(posedge clk) begin
		if (load && idle) begin
			mag_q   <= value[sdf_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
			neg_q   <= value[sdf_pkg::VALUE_W-1];
			space_q <= space;
		end else if (running) begin
			mag_q <= {mag_q[sdf_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	// Row of digit cells, lowest digit takes the magnitude MSB
	for (genvar i = 0; i < sdf_pkg::NUM_DIGITS; i++) begin : g_cell
		logic din;
		if (i == 0) begin : g_first
			assign din = mag_q[sdf_pkg::VALUE_W-1];
		end else begin : g_next
			assign din = carry[i-1];
		end
		sdf_bcd_cell u_cell (
			.clk   (clk),
			.clr   (load && idle),
			.shift (running),
			.din   (din),
			.dout  (carry[i]),
			.digit (digits[i])
		);
	end

	// Hand the finished digits over; the top carry never rises for a 32-bit magnitude
	always_comb begin
		res.valid  = (state_q == ST_DONE) && !carry[sdf_pkg::NUM_DIGITS-1];
		res.space  = space_q;
		res.neg    = neg_q;
		res.digits = digits;
	end

endmodule

[rtl/sdf_emit.sv]
// Character emitter: walks space, minus and the significant digits into an output register.
// Holds one converted number so the converter can start on the next.
// Depends on sdf_pkg.
`timescale 1ns / 1ps

module sdf_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sdf_pkg::conv_result_t         res,
	output logic                          take,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sdf_pkg::CHAR_W-1:0]    out_char,
	output logic                          out_last
);

	logic                                            busy_q;
	logic                                            pend_space_q;
	logic                                            pend_neg_q;
	logic [sdf_pkg::IDX_W-1:0]                       idx_q;
	logic [sdf_pkg::NUM_DIGITS-1:0][sdf_pkg::BCD_W-1:0] digits_q;
	logic                                            out_valid_q;
	logic [sdf_pkg::CHAR_W-1:0]                      char_q;
	logic                                            last_q;
	logic [sdf_pkg::IDX_W-1:0]                       top_idx;
	logic                                            advance;

	assign take    = res.valid && !busy_q;
	assign advance = busy_q && (!out_valid_q || out_ready);

	// Find the highest nonzero digit; zero gives the units digit alone
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < sdf_pkg::NUM_DIGITS; i++) begin
			if (res.digits[i] != '0) begin
				top_idx = sdf_pkg::IDX_W'(i);
			end
		end
	end

	// Step through the characters of the held number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			pend_space_q <= 1'b0;
			pend_neg_q   <= 1'b0;
			idx_q        <= '0;
		end else if (take) begin
			busy_q       <= 1'b1;
			pend_space_q <= res.space;
			pend_neg_q   <= res.neg;
			idx_q        <= top_idx;
		end else if (advance) begin
			if (pend_space_q) begin
				pend_space_q <= 1'b0;
			end else if (pend_neg_q) begin
				pend_neg_q <= 1'b0;
			end else if (idx_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	// Hold the digits of the number being emitted
	always_ff @(posedge clk) begin
		if (take) begin
			digits_q <= res.digits;
		end
	end

	// Output register: load a beat when empty or when the current one leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (pend_space_q) begin
				char_q <= sdf_pkg::CH_SPACE;
				last_q <= 1'b0;
			end else if (pend_neg_q) begin
				char_q <= sdf_pkg::CH_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= sdf_pkg::CH_ZERO + sdf_pkg::CHAR_W'(digits_q[idx_q]);
				last_q <= (idx_q == '0);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

endmodule

[rtl/signed_decimal_formatter_unit.sv]
// Signed decimal formatter: a 32-bit signed value in, its ASCII text out one character a beat.
// A value passes the bit-serial shift through the BCD cell row, the handoff to the emitter and
// the output register. The converter takes a new value once the emitter has taken the last
// result, so the next value converts while up to 12 characters of the previous one stream out.
// Reset (arst_n low, asynchronous) empties the converter, the emitter and the output register.
// Depends on sdf_pkg, sdf_convert, sdf_emit.
`timescale 1ns / 1ps

module signed_decimal_formatter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tuser,   // [0] leading_space
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] ascii_char, [7] zero
	output logic        m_tlast    // last_char
);

	sdf_pkg::conv_result_t        res;
	logic                         take;
	logic                         conv_idle;
	logic [sdf_pkg::CHAR_W-1:0]   out_char;

	assign s_tready = conv_idle;

	sdf_convert u_convert (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (s_tvalid),
		.value  (s_tdata),
		.space  (s_tuser),
		.take   (take),
		.idle   (conv_idle),
		.res    (res)
	);

	sdf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.take      (take),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (out_char),
		.out_last  (m_tlast)
	);

	assign m_tdata = {1'b0, out_char};

	// An accepted beat starts a conversion, so no second beat follows at once
	a_busy_after_accept : assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	// A handoff only happens from a finished conversion
	a_take_needs_result : assert property (@(posedge clk) disable iff (!arst_n)
		take |-> res.valid && !conv_idle)
		else $error("emitter took digits with no finished conversion");

	// Every character is a space, a minus or a digit
	a_char_set : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_char == sdf_pkg::CH_SPACE) || (out_char == sdf_pkg::CH_MINUS) ||
			((out_char >= sdf_pkg::CH_ZERO) && (out_char <= sdf_pkg::CH_NINE)))
		else $error("character outside the output set");

	// The final character is always a digit
	a_last_is_digit : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (out_char >= sdf_pkg::CH_ZERO) && (out_char <= sdf_pkg::CH_NINE))
		else $error("last character is not a digit");

endmodule

[verif/signed_decimal_formatter_unit_tb.sv]
// Testbench for signed_decimal_formatter_unit: streams signed 32-bit numbers in and checks every
// ASCII character beat against set text or a local decimal formatter, under random idling on both sides.
// Depends on sdf_pkg and the signed_decimal_formatter_unit RTL.
`timescale 1ns / 1ps

module signed_decimal_formatter_unit_tb;

	localparam int RANDOM_NUMBERS = 257;
	localparam int MAX_WAIT       = 13;
	// Cycles with no beat on either side before the run is called hung
	localparam int HANG_LIMIT     = 2000;
	// Input beat to first character, with margin
	localparam int DRAIN_CYCLES   = 40;

	// One character beat as it should leave the block
	typedef struct {
		logic [sdf_pkg::CHAR_W-1:0] code;
		logic                       last;
	} char_beat_t;

	// One directed number; an empty text means the formatter below supplies the characters
	typedef struct {
		logic [31:0] value;
		logic        space;
		string       text;
	} number_row_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;    // [31:0] value
	logic        s_tuser  = 1'b0;  // [0] leading_space
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;          // [6:0] ascii_char, [7] zero
	logic        m_tlast;          // last_char

	char_beat_t pending_chars[$];
	string      typed_text_q[$];
	int         mismatches   = 0;
	int         numbers_sent = 0;
	int         negatives    = 0;
	int         spaced       = 0;
	int         chars_seen   = 0;
	int         idle_cycles  = 0;
	int         rx_count     = 0;

	number_row_t number_rows[23] = '{
		'{32'd0,           1'b0, "0"},
		'{32'd0,           1'b1, " 0"},
		'{32'd1,           1'b0, "1"},
		'{-32'sd1,         1'b0, "-1"},
		'{-32'sd1,         1'b1, " -1"},
		'{32'h7FFF_FFFF,   1'b0, "2147483647"},
		'{32'h7FFF_FFFF,   1'b1, " 2147483647"},
		'{32'h8000_0000,   1'b0, "-2147483648"},
		'{32'h8000_0000,   1'b1, " -2147483648"},
		'{32'h8000_0001,   1'b0, "-2147483647"},
		'{32'd9,           1'b0, ""},
		'{32'd10,          1'b0, ""},
		'{-32'sd10,        1'b1, ""},
		'{32'd99,          1'b0, ""},
		'{32'd100,         1'b1, ""},
		'{32'd999999999,   1'b0, ""},
		'{32'd1000000000,  1'b0, ""},
		'{-32'sd1000000000, 1'b0, ""},
		'{32'd1000000001,  1'b1, ""},
		'{32'd1234567890,  1'b0, ""},
		'{-32'sd987654321, 1'b1, ""},
		'{32'h5555_5555,   1'b0, ""},
		'{32'hAAAA_AAAA,   1'b1, ""}
	};

	signed_decimal_formatter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Queue the characters of one number: optional space, sign, digits without leading zeros
	function automatic void format_decimal(input logic [31:0] value, input logic space);
		logic [31:0] magnitude;
		logic [31:0] divisor;
		logic [31:0] digit;
		logic        started;
		magnitude = value[31] ? (~value + 32'd1) : value;
		started   = 1'b0;
		divisor   = 32'd1000000000;
		if (space)
			pending_chars.push_back('{sdf_pkg::CH_SPACE, 1'b0});
		if (value[31])
			pending_chars.push_back('{sdf_pkg::CH_MINUS, 1'b0});
		while (divisor != 0) begin
			digit     = magnitude / divisor;
			magnitude = magnitude % divisor;
			if (digit != 0)
				started = 1'b1;
			if (started || divisor == 32'd1)
				pending_chars.push_back('{sdf_pkg::CH_ZERO + digit[sdf_pkg::CHAR_W-1:0],
					divisor == 32'd1});
			divisor = divisor / 32'd10;
		end
	endfunction

	// Offer one number after a random gap and hold it until the block takes it
	task automatic send_number(input logic [31:0] value, input logic space, input string text);
		int gap;
		gap = (numbers_sent % 50 < 12) ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		typed_text_q.push_back(text);
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= space;
		do @(posedge clk); while (!s_tready);
	endtask

	// Record the expected text of each accepted number
	always @(posedge clk) begin : take_number
		string text;
		byte   ch;
		if (arst_n && s_tvalid && s_tready) begin
			text = typed_text_q.pop_front();
			if (text.len() == 0) begin
				format_decimal(s_tdata, s_tuser);
			end else begin
				for (int i = 0; i < text.len(); i++) begin
					ch = text[i];
					pending_chars.push_back('{ch[sdf_pkg::CHAR_W-1:0], i == text.len() - 1});
				end
			end
			numbers_sent++;
			if (s_tdata[31])
				negatives++;
			if (s_tuser)
				spaced++;
		end
	end

	// Compare each character beat with the oldest expected one
	always @(posedge clk) begin : check_char
		char_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			chars_seen++;
			if (pending_chars.size() == 0) begin
				$error("unexpected character 0x%02h with no number pending",
					m_tdata[sdf_pkg::CHAR_W-1:0]);
				mismatches++;
			end else begin
				want = pending_chars.pop_front();
				if (m_tdata[sdf_pkg::CHAR_W-1:0] !== want.code) begin
					$error("ascii_char: expected 0x%02h, got 0x%02h", want.code,
						m_tdata[sdf_pkg::CHAR_W-1:0]);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("last_char: expected %0b, got %0b", want.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// Stop a hung run: count cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= HANG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Output side: stall a random number of cycles before each character, with bursts of none
	initial begin : drain_chars
		int stall;
		wait (arst_n);
		forever begin
			stall = (rx_count % 70 < 20) ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			rx_count++;
		end
	end

	initial begin : run_numbers
		logic [31:0] value;
		int          power;
		int          offset;
		int          width;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed numbers: zero, extremes, sign and space combinations, digit-count steps
		foreach (number_rows[i])
			send_number(number_rows[i].value, number_rows[i].space, number_rows[i].text);

		// Random numbers from several shapes
		for (int k = 0; k < RANDOM_NUMBERS; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: value = $urandom;
				4, 5: begin
					value = $urandom_range(0, 20);
					if ($urandom_range(0, 1))
						value = -value;
				end
				6, 7: begin
					power = 1;
					repeat ($urandom_range(0, 9)) power = power * 10;
					offset = $urandom_range(0, 4) - 2;
					value  = power + offset;
					if ($urandom_range(0, 1))
						value = -value;
				end
				8: begin
					case ($urandom_range(0, 3))
						0: value = 32'h7FFF_FFFF;
						1: value = 32'h8000_0000;
						2: value = 32'h8000_0001;
						default: value = 32'd0;
					endcase
				end
				default: begin
					width = $urandom_range(1, 31);
					value = $urandom & ((32'd1 << width) - 32'd1);
					if ($urandom_range(0, 1))
						value = -value;
				end
			endcase
			send_number(value, $urandom_range(0, 1), "");
		end
		s_tvalid <= 1'b0;
		// Let the last accepted number reach the expected queue
		@(posedge clk);

		// Wait out the remaining characters, then watch for strays
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Formatted %0d numbers (%0d negative, %0d with a leading space)",
			numbers_sent, negatives, spaced);
		$display("Compared %0d character beats, %0d field mismatches", chars_seen, mismatches);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
rtl/sdf_pkg.sv
rtl/sdf_bcd_cell.sv
rtl/sdf_convert.sv
rtl/sdf_emit.sv
rtl/signed_decimal_formatter_unit.sv
verif/signed_decimal_formatter_unit_tb.sv
